// ===== design/irpd_pkg.sv =====
// shared types and constants of the ir pulse-distance frame decoder
// used by irpd_classify and ir_pulse_distance_frame_decoder; no dependencies

package irpd_pkg;

    localparam int DUR_W    = 24;
    localparam int NUM_REGS = 7;
    localparam int CFG_IDX_W = 3;
    localparam int KIND_W   = 2;
    localparam int OUT_W    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ABOVE = 3'd6;

    localparam logic [DUR_W-1:0] RST_SHORT_MIN    = 24'd450;
    localparam logic [DUR_W-1:0] RST_SHORT_MAX    = 24'd650;
    localparam logic [DUR_W-1:0] RST_LONG_MIN     = 24'd1500;
    localparam logic [DUR_W-1:0] RST_LONG_MAX     = 24'd1750;
    localparam logic [DUR_W-1:0] RST_PREAMBLE_MIN = 24'd5000;
    localparam logic [DUR_W-1:0] RST_PREAMBLE_MAX = 24'd8000;
    localparam logic [DUR_W-1:0] RST_IGNORE_ABOVE = 24'd10000;

    localparam logic [KIND_W-1:0] KIND_ODD_PULSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ODD_SPACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE      = 2'd2;

    typedef logic [NUM_REGS-1:0][DUR_W-1:0] cfg_regs_t;

    typedef struct packed {
        logic ignore;
        logic hit_short;
        logic hit_long;
        logic hit_pre;
    } class_t;

endpackage

// ===== design/ir_pulse_distance_frame_decoder.sv =====
// top level of the ir pulse-distance frame decoder: control, frame memories, output register
// depends on irpd_pkg and irpd_classify

// usage
// - s_* takes one mark or space per transaction: s_tdata holds the duration,
//   s_tuser the pulse flag
// - m_* gives result transactions: unclassified durations, or a flushed frame
//   byte by byte with the mask of bits changed since the previous frame;
//   m_tlast marks the final result of one input transaction
// - cfg_* writes one window register per transaction, always ready; write only
//   while the block is idle
// - each input passes through capture (idle) and classify with memory write-back
//   (eval); eval registers an unclassified duration onto m_* once the output is free
// - the frame flush reads the frame and previous-frame memories one entry at
//   a time through their registered read port: a read state, then an output
//   state per byte, and the output state waits while m_* is stalled
// - reset clears counters and the previous-frame flag and loads the default windows; no memory pass
// - when m_tready is low the output register holds and the control waits,
//   s_tready stays low until the pending item is done

module ir_pulse_distance_frame_decoder
#(
    parameter int FRAME_BYTES = 13
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [irpd_pkg::DUR_W-1:0]        s_tdata,    // duration
    input  logic                              s_tuser,    // is_pulse
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [irpd_pkg::OUT_W-1:0]        m_tdata,    // odd_length, byte_value,
                                                          // byte_index, diff_mask, zero pad
    output logic [irpd_pkg::KIND_W-1:0]       m_tuser,    // kind
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpd_pkg::DUR_W-1:0]        cfg_data
);

    localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    irpd_pkg::cfg_regs_t          cfg_reg;
    logic [irpd_pkg::DUR_W-1:0]   dur_reg, dur_next;
    logic                         pulse_reg, pulse_next;
    logic [7:0]                   shift_reg, shift_next;
    logic [2:0]                   bitcnt_reg, bitcnt_next;
    logic [IDX_W-1:0]             bytecnt_reg, bytecnt_next;
    logic [IDX_W-1:0]             fidx_reg, fidx_next;
    logic                         prev_valid_reg, prev_valid_next;

    logic                         out_valid_reg, out_valid_next;
    logic [irpd_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [irpd_pkg::DUR_W-1:0]   out_len_reg, out_len_next;
    logic [7:0]                   out_val_reg, out_val_next;
    logic [4:0]                   out_idx_reg, out_idx_next;
    logic [7:0]                   out_mask_reg, out_mask_next;
    logic                         out_last_reg, out_last_next;

    logic [7:0]                   frame_mem [FRAME_BYTES];
    logic [7:0]                   prev_mem  [FRAME_BYTES];
    logic [7:0]                   fs_rd_reg;
    logic [7:0]                   pf_rd_reg;
    logic                         fs_we;
    logic                         pf_we;
    logic                         mem_re;

    irpd_pkg::class_t             cls;
    logic                         out_free;

    irpd_classify u_classify
    (
        .duration (dur_reg),
        .cfg_regs (cfg_reg),
        .cls      (cls)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[irpd_pkg::REG_SHORT_MIN]    <= irpd_pkg::RST_SHORT_MIN;
            cfg_reg[irpd_pkg::REG_SHORT_MAX]    <= irpd_pkg::RST_SHORT_MAX;
            cfg_reg[irpd_pkg::REG_LONG_MIN]     <= irpd_pkg::RST_LONG_MIN;
            cfg_reg[irpd_pkg::REG_LONG_MAX]     <= irpd_pkg::RST_LONG_MAX;
            cfg_reg[irpd_pkg::REG_PREAMBLE_MIN] <= irpd_pkg::RST_PREAMBLE_MIN;
            cfg_reg[irpd_pkg::REG_PREAMBLE_MAX] <= irpd_pkg::RST_PREAMBLE_MAX;
            cfg_reg[irpd_pkg::REG_IGNORE_ABOVE] <= irpd_pkg::RST_IGNORE_ABOVE;
        end
        else if (cfg_valid && (cfg_index <= irpd_pkg::REG_IGNORE_ABOVE))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        dur_next        = dur_reg;
        pulse_next      = pulse_reg;
        shift_next      = shift_reg;
        bitcnt_next     = bitcnt_reg;
        bytecnt_next    = bytecnt_reg;
        fidx_next       = fidx_reg;
        prev_valid_next = prev_valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_len_next    = out_len_reg;
        out_val_next    = out_val_reg;
        out_idx_next    = out_idx_reg;
        out_mask_next   = out_mask_reg;
        out_last_next   = out_last_reg;
        fs_we           = 1'b0;
        pf_we           = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dur_next   = s_tdata;
                    pulse_next = s_tuser;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (cls.ignore)
                begin
                    state_next = ST_IDLE;
                end
                else if (!cls.hit_short && !cls.hit_long && !cls.hit_pre)
                begin
                    // unclassified duration, reported once the output is free
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pulse_reg ? irpd_pkg::KIND_ODD_PULSE
                                                   : irpd_pkg::KIND_ODD_SPACE;
                        out_len_next   = dur_reg;
                        out_val_next   = 8'd0;
                        out_idx_next   = 5'd0;
                        out_mask_next  = 8'd0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (pulse_reg || (!cls.hit_short && !cls.hit_long))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    shift_next  = {shift_reg[6:0], !cls.hit_short};
                    bitcnt_next = bitcnt_reg + 3'd1;
                    state_next  = ST_IDLE;
                    if (bitcnt_reg == 3'd7)
                    begin
                        fs_we = 1'b1;
                        if (bytecnt_reg == LAST_IDX)
                        begin
                            fidx_next  = '0;
                            state_next = ST_RD;
                        end
                        else
                        begin
                            bytecnt_next = bytecnt_reg + IDX_W'(1);
                        end
                    end
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    pf_we          = 1'b1;
                    out_valid_next = 1'b1;
                    out_kind_next  = irpd_pkg::KIND_BYTE;
                    out_len_next   = '0;
                    out_val_next   = fs_rd_reg;
                    out_idx_next   = 5'(fidx_reg);
                    out_mask_next  = prev_valid_reg ? (fs_rd_reg ^ pf_rd_reg) : 8'd0;
                    out_last_next  = (fidx_reg == LAST_IDX);
                    if (fidx_reg == LAST_IDX)
                    begin
                        prev_valid_next = 1'b1;
                        bytecnt_next    = '0;
                        bitcnt_next     = 3'd0;
                        shift_next      = 8'd0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        fidx_next  = fidx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            shift_reg      <= 8'd0;
            bitcnt_reg     <= 3'd0;
            bytecnt_reg    <= '0;
            fidx_reg       <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            shift_reg      <= shift_next;
            bitcnt_reg     <= bitcnt_next;
            bytecnt_reg    <= bytecnt_next;
            fidx_reg       <= fidx_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dur_reg      <= dur_next;
        pulse_reg    <= pulse_next;
        out_kind_reg <= out_kind_next;
        out_len_reg  <= out_len_next;
        out_val_reg  <= out_val_next;
        out_idx_reg  <= out_idx_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
    end

    // frame memory: byte write on completion, registered read during flush
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            frame_mem[bytecnt_reg] <= shift_next;
        end
        if (mem_re)
        begin
            fs_rd_reg <= frame_mem[fidx_reg];
        end
    end

    // previous-frame memory: read with the frame byte, written back on output
    always_ff @(posedge clk)
    begin
        if (pf_we)
        begin
            prev_mem[fidx_reg] <= fs_rd_reg;
        end
        if (mem_re)
        begin
            pf_rd_reg <= prev_mem[fidx_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_mask_reg, out_idx_reg, out_val_reg, out_len_reg};

    a_byte_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bytecnt_reg <= LAST_IDX)
        else $error("byte count beyond frame");

    a_odd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != irpd_pkg::KIND_BYTE) |-> m_tlast && (m_tdata[47:24] == 24'd0))
        else $error("unclassified result with byte fields or without last");

    a_last_byte_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && (m_tuser == irpd_pkg::KIND_BYTE)
        |-> (m_tdata[36:32] == 5'(LAST_IDX)))
        else $error("frame ended at wrong byte index");

    a_prev_valid_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && (m_tuser == irpd_pkg::KIND_BYTE) |-> prev_valid_reg)
        else $error("previous frame flag not set after flush");

    a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && !out_free |=> (state_reg == ST_OUT))
        else $error("flush left while output stalled");

endmodule

// ===== design/irpd_classify.sv =====
// window classifier: sorts one duration against the configured windows
// depends on irpd_pkg

module irpd_classify
(
    input  logic [irpd_pkg::DUR_W-1:0] duration,
    input  irpd_pkg::cfg_regs_t        cfg_regs,
    output irpd_pkg::class_t           cls
);

    always_comb
    begin
        cls.ignore    = duration > cfg_regs[irpd_pkg::REG_IGNORE_ABOVE];
        cls.hit_short = (duration >= cfg_regs[irpd_pkg::REG_SHORT_MIN]) &&
                        (duration <= cfg_regs[irpd_pkg::REG_SHORT_MAX]);
        cls.hit_long  = (duration >= cfg_regs[irpd_pkg::REG_LONG_MIN]) &&
                        (duration <= cfg_regs[irpd_pkg::REG_LONG_MAX]);
        cls.hit_pre   = (duration >= cfg_regs[irpd_pkg::REG_PREAMBLE_MIN]) &&
                        (duration <= cfg_regs[irpd_pkg::REG_PREAMBLE_MAX]);
    end

endmodule

// ===== verif/ir_pulse_distance_frame_decoder_tb.sv =====
// testbench of ir_pulse_distance_frame_decoder: edge durations, then random frames and noise
// under several window settings, each result checked against a built-in decoder
// depends on irpd_pkg and the design files

module ir_pulse_distance_frame_decoder_tb;

    localparam int FRAME_LEN     = 13;
    localparam int REPORT_LIMIT  = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int EDGE_COUNT    = 23;
    localparam logic [irpd_pkg::DUR_W-1:0] DUR_MAX = '1;

    typedef struct packed {
        logic [irpd_pkg::KIND_W-1:0] kind;
        logic [irpd_pkg::DUR_W-1:0]  odd_length;
        logic [7:0]                  byte_value;
        logic [4:0]                  byte_index;
        logic [7:0]                  diff_mask;
        logic                        last;
    } ir_result_t;

    class ir_decode_scoreboard;
        logic [irpd_pkg::DUR_W-1:0] window [irpd_pkg::NUM_REGS];
        logic [7:0]       bit_shift;
        logic [2:0]       bit_count;
        logic [4:0]       byte_count;
        logic [7:0]       frame_bytes [FRAME_LEN];
        logic [7:0]       prev_bytes [FRAME_LEN];
        bit               prev_valid;
        ir_result_t       pending_results [$];
        int               bad_results;

        function new();
            window[irpd_pkg::REG_SHORT_MIN]    = irpd_pkg::RST_SHORT_MIN;
            window[irpd_pkg::REG_SHORT_MAX]    = irpd_pkg::RST_SHORT_MAX;
            window[irpd_pkg::REG_LONG_MIN]     = irpd_pkg::RST_LONG_MIN;
            window[irpd_pkg::REG_LONG_MAX]     = irpd_pkg::RST_LONG_MAX;
            window[irpd_pkg::REG_PREAMBLE_MIN] = irpd_pkg::RST_PREAMBLE_MIN;
            window[irpd_pkg::REG_PREAMBLE_MAX] = irpd_pkg::RST_PREAMBLE_MAX;
            window[irpd_pkg::REG_IGNORE_ABOVE] = irpd_pkg::RST_IGNORE_ABOVE;
            bit_shift   = '0;
            bit_count   = '0;
            byte_count  = '0;
            prev_valid  = 1'b0;
            bad_results = 0;
            foreach (frame_bytes[i])
            begin
                frame_bytes[i] = '0;
                prev_bytes[i]  = '0;
            end
        endfunction

        function void write_window(logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [irpd_pkg::DUR_W-1:0] value);
            window[idx] = value;
        endfunction

        function bit in_range(logic [irpd_pkg::DUR_W-1:0] d, logic [irpd_pkg::DUR_W-1:0] lo,
                              logic [irpd_pkg::DUR_W-1:0] hi);
            return d >= lo && d <= hi;
        endfunction

        function void take_duration(logic [irpd_pkg::DUR_W-1:0] d, logic pulse);
            ir_result_t r;
            bit hit_short;
            bit hit_long;
            bit hit_pre;
            hit_short = in_range(d, window[irpd_pkg::REG_SHORT_MIN],
                                 window[irpd_pkg::REG_SHORT_MAX]);
            hit_long  = in_range(d, window[irpd_pkg::REG_LONG_MIN],
                                 window[irpd_pkg::REG_LONG_MAX]);
            hit_pre   = in_range(d, window[irpd_pkg::REG_PREAMBLE_MIN],
                                 window[irpd_pkg::REG_PREAMBLE_MAX]);
            if (d > window[irpd_pkg::REG_IGNORE_ABOVE])
                return;
            if (!hit_short && !hit_long && !hit_pre)
            begin
                r = '0;
                r.kind = pulse ? irpd_pkg::KIND_ODD_PULSE : irpd_pkg::KIND_ODD_SPACE;
                r.odd_length = d;
                r.last = 1'b1;
                pending_results.push_back(r);
                return;
            end
            // classified pulses and preamble spaces leave the counters alone
            if (pulse || !(hit_short || hit_long))
                return;
            bit_shift = {bit_shift[6:0], !hit_short};
            bit_count = bit_count + 3'd1;
            if (bit_count != 0)
                return;
            frame_bytes[byte_count] = bit_shift;
            if (int'(byte_count) + 1 < FRAME_LEN)
            begin
                byte_count = byte_count + 5'd1;
                return;
            end
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                r = '0;
                r.kind       = irpd_pkg::KIND_BYTE;
                r.byte_value = frame_bytes[i];
                r.byte_index = i[4:0];
                r.diff_mask  = prev_valid ? (frame_bytes[i] ^ prev_bytes[i]) : 8'h00;
                r.last       = (i == FRAME_LEN - 1);
                pending_results.push_back(r);
                prev_bytes[i] = frame_bytes[i];
            end
            prev_valid = 1'b1;
            byte_count = '0;
            bit_shift  = '0;
            bit_count  = '0;
        endfunction

        function void check_result(ir_result_t got);
            ir_result_t want;
            if (pending_results.size() == 0)
            begin
                if (bad_results < REPORT_LIMIT)
                    $display("unexpected result: kind=%0d len=%0d byte=%h idx=%0d mask=%h last=%0d",
                             got.kind, got.odd_length, got.byte_value, got.byte_index,
                             got.diff_mask, got.last);
                bad_results++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                if (bad_results < REPORT_LIMIT)
                begin
                    $display("wrong result: expected kind=%0d len=%0d byte=%h idx=%0d mask=%h last=%0d",
                             want.kind, want.odd_length, want.byte_value, want.byte_index,
                             want.diff_mask, want.last);
                    $display("              got      kind=%0d len=%0d byte=%h idx=%0d mask=%h last=%0d",
                             got.kind, got.odd_length, got.byte_value, got.byte_index,
                             got.diff_mask, got.last);
                end
                bad_results++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [irpd_pkg::DUR_W-1:0]     s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [irpd_pkg::OUT_W-1:0]     m_tdata;
    logic [irpd_pkg::KIND_W-1:0]    m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [irpd_pkg::DUR_W-1:0]     cfg_data;

    ir_decode_scoreboard decoder_model = new();
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned cycles = 0;

    logic [irpd_pkg::DUR_W-1:0] edge_dur [EDGE_COUNT] = '{
        24'd0, 24'd0, DUR_MAX, DUR_MAX, irpd_pkg::RST_IGNORE_ABOVE,
        irpd_pkg::RST_IGNORE_ABOVE + 24'd1,
        24'd560, irpd_pkg::RST_SHORT_MIN - 24'd1, irpd_pkg::RST_SHORT_MIN - 24'd1,
        irpd_pkg::RST_SHORT_MIN, irpd_pkg::RST_SHORT_MAX,
        irpd_pkg::RST_SHORT_MAX + 24'd1, irpd_pkg::RST_LONG_MIN - 24'd1,
        irpd_pkg::RST_LONG_MIN, irpd_pkg::RST_LONG_MAX,
        irpd_pkg::RST_LONG_MAX + 24'd1, irpd_pkg::RST_PREAMBLE_MIN,
        irpd_pkg::RST_PREAMBLE_MIN, irpd_pkg::RST_PREAMBLE_MAX,
        irpd_pkg::RST_PREAMBLE_MAX + 24'd1, irpd_pkg::RST_IGNORE_ABOVE - 24'd1,
        24'hAAAAAA, 24'h555555
    };
    logic edge_pulse [EDGE_COUNT] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1
    };

    ir_pulse_distance_frame_decoder
    #(
        .FRAME_BYTES (FRAME_LEN)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            decoder_model.check_result({m_tuser, m_tdata[23:0], m_tdata[31:24],
                                        m_tdata[36:32], m_tdata[44:37], m_tlast});
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(logic [irpd_pkg::DUR_W-1:0] d, logic pulse);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= pulse;
        do
            @(posedge clk);
        while (!s_tready);
        decoder_model.take_duration(d, pulse);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // results may still be in flight after an item that yields none
    task automatic settle();
        while (decoder_model.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                                logic [irpd_pkg::DUR_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        decoder_model.write_window(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_windows(logic [irpd_pkg::DUR_W-1:0] s_lo,
                                logic [irpd_pkg::DUR_W-1:0] s_hi,
                                logic [irpd_pkg::DUR_W-1:0] l_lo,
                                logic [irpd_pkg::DUR_W-1:0] l_hi,
                                logic [irpd_pkg::DUR_W-1:0] p_lo,
                                logic [irpd_pkg::DUR_W-1:0] p_hi,
                                logic [irpd_pkg::DUR_W-1:0] ignore);
        write_window(irpd_pkg::REG_SHORT_MIN, s_lo);
        write_window(irpd_pkg::REG_SHORT_MAX, s_hi);
        write_window(irpd_pkg::REG_LONG_MIN, l_lo);
        write_window(irpd_pkg::REG_LONG_MAX, l_hi);
        write_window(irpd_pkg::REG_PREAMBLE_MIN, p_lo);
        write_window(irpd_pkg::REG_PREAMBLE_MAX, p_hi);
        write_window(irpd_pkg::REG_IGNORE_ABOVE, ignore);
    endtask

    function automatic logic [irpd_pkg::DUR_W-1:0] pick_in(logic [irpd_pkg::DUR_W-1:0] lo,
                                                           logic [irpd_pkg::DUR_W-1:0] hi);
        if (lo > hi)
            return irpd_pkg::DUR_W'($urandom_range(0, DUR_MAX));
        return lo + irpd_pkg::DUR_W'($urandom_range(0, hi - lo));
    endfunction

    function automatic logic [irpd_pkg::DUR_W-1:0] near_edge();
        case ($urandom_range(0, 6))
            0: return decoder_model.window[irpd_pkg::REG_SHORT_MIN] - 24'd1;
            1: return decoder_model.window[irpd_pkg::REG_SHORT_MAX] + 24'd1;
            2: return decoder_model.window[irpd_pkg::REG_LONG_MIN] - 24'd1;
            3: return decoder_model.window[irpd_pkg::REG_LONG_MAX] + 24'd1;
            4: return decoder_model.window[irpd_pkg::REG_PREAMBLE_MAX] + 24'd1;
            5: return decoder_model.window[irpd_pkg::REG_IGNORE_ABOVE];
            default: return decoder_model.window[irpd_pkg::REG_IGNORE_ABOVE] + 24'd1;
        endcase
    endfunction

    // mostly well-formed frames: optional mark, then a short or long space per bit
    task automatic run_phase(int tx_pct, int rx_pct, int quota);
        int done;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        done = 0;
        while (done < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                if ($urandom_range(0, 99) < 40)
                begin
                    send_item(pick_in(decoder_model.window[irpd_pkg::REG_SHORT_MIN],
                                      decoder_model.window[irpd_pkg::REG_SHORT_MAX]), 1'b1);
                    done++;
                end
                if ($urandom_range(0, 1))
                    send_item(pick_in(decoder_model.window[irpd_pkg::REG_LONG_MIN],
                                      decoder_model.window[irpd_pkg::REG_LONG_MAX]), 1'b0);
                else
                    send_item(pick_in(decoder_model.window[irpd_pkg::REG_SHORT_MIN],
                                      decoder_model.window[irpd_pkg::REG_SHORT_MAX]), 1'b0);
                done++;
            end
            else if (pick < 82)
            begin
                send_item(pick_in(decoder_model.window[irpd_pkg::REG_PREAMBLE_MIN],
                                  decoder_model.window[irpd_pkg::REG_PREAMBLE_MAX]), 1'b1);
                send_item(pick_in(decoder_model.window[irpd_pkg::REG_PREAMBLE_MIN],
                                  decoder_model.window[irpd_pkg::REG_PREAMBLE_MAX]), 1'b0);
                done += 2;
            end
            else if (pick < 90)
            begin
                send_item(near_edge(), 1'($urandom_range(0, 1)));
                done++;
            end
            else
            begin
                send_item(irpd_pkg::DUR_W'($urandom_range(0, DUR_MAX)),
                          1'($urandom_range(0, 1)));
                done++;
            end
        end
        stop_sending();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = irpd_pkg::REG_SHORT_MIN;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 28;
        rx_idle_pct = 48;
        for (int i = 0; i < EDGE_COUNT; i++)
            send_item(edge_dur[i], edge_pulse[i]);
        stop_sending();
        settle();

        // widest values: short from zero, preamble up to the top, nothing ignored
        load_windows(24'd0, 24'd100, 24'd101, 24'd300, 24'd16777000, DUR_MAX, DUR_MAX);
        run_phase(28, 48, 128);
        settle();

        // short and long overlap, preamble window empty
        load_windows(24'd200, 24'd900, 24'd500, 24'd1500, 24'd4000, 24'd3000, 24'd5000);
        run_phase(48, 28, 128);
        settle();

        write_window(irpd_pkg::REG_IGNORE_ABOVE, 24'd0);
        send_item(24'd0, 1'b0);
        send_item(24'd1, 1'b1);
        send_item(DUR_MAX, 1'b0);
        stop_sending();
        settle();

        load_windows(irpd_pkg::RST_SHORT_MIN, irpd_pkg::RST_SHORT_MAX,
                     irpd_pkg::RST_LONG_MIN, irpd_pkg::RST_LONG_MAX,
                     irpd_pkg::RST_PREAMBLE_MIN, irpd_pkg::RST_PREAMBLE_MAX,
                     irpd_pkg::RST_IGNORE_ABOVE);
        run_phase(0, 0, 128);
        settle();

        if (decoder_model.bad_results == 0 && decoder_model.pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
